@@ hw/rtl/uvg_pkg.sv @@
package uvg_pkg;

  localparam int unsigned TS_W    = 60;
  localparam int unsigned SEC_W   = 34;
  localparam int unsigned NSEC_W  = 30;
  localparam int unsigned NODE_W  = 48;
  localparam int unsigned SEQ_W   = 14;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned IN_W    = 136;
  localparam int unsigned OUT_W   = 128;

  localparam int unsigned SEC_HALF_W = 17;
  localparam int unsigned TPS_W      = 24;
  localparam int unsigned PROD_W     = SEC_HALF_W + TPS_W;
  localparam int unsigned RECIP_W    = 31;
  localparam int unsigned RECIP_SH   = 37;
  localparam int unsigned QPROD_W    = NSEC_W + RECIP_W;
  localparam int unsigned TICK_W     = QPROD_W - RECIP_SH;

  localparam logic [TS_W-1:0]    GREG_OFFSET   = 60'h1B21DD213814000;
  localparam logic [TPS_W-1:0]   TICKS_PER_SEC = 24'd10000000;
  localparam logic [RECIP_W-1:0] RECIP_100     = 31'h51EB851F;
  localparam logic [CNT_W-1:0]   MAX_BATCH     = 7'd64;
  localparam logic [3:0]         VERSION_NIB   = 4'h1;
  localparam logic [1:0]         VARIANT_BITS  = 2'b10;
  localparam int unsigned        MCAST_BIT     = 40;

  typedef struct packed {
    logic [TS_W-1:0]   ts;
    logic [SEQ_W-1:0]  seq;
    logic [NODE_W-1:0] node;
    logic [CNT_W-1:0]  count;
  } cmd_t;

endpackage

@@ hw/rtl/uvg_front.sv @@
module uvg_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [uvg_pkg::IN_W-1:0]   in_data,
  input  logic                       in_random,
  output logic                       push,
  output uvg_pkg::cmd_t              push_cmd,
  input  logic                       q_full
);

  logic                             v1, v2, v3;
  logic [uvg_pkg::PROD_W-1:0]       p_lo, p_hi;
  logic [uvg_pkg::TICK_W-1:0]       ticks;
  logic [uvg_pkg::NODE_W-1:0]       node1, node2, node3;
  logic [uvg_pkg::SEQ_W-1:0]        rnd1, rnd2, rnd3;
  logic [uvg_pkg::CNT_W-1:0]        cnt1, cnt2, cnt3;
  logic [uvg_pkg::TS_W-1:0]         ts3;

  logic [uvg_pkg::TS_W-1:0]         last_ts;
  logic [uvg_pkg::NODE_W-1:0]       last_node;
  logic [uvg_pkg::SEQ_W-1:0]        last_seq;

  logic [uvg_pkg::SEC_W-1:0]        sec;
  logic [uvg_pkg::NSEC_W-1:0]       nsec;
  logic [uvg_pkg::NODE_W-1:0]       node_in;
  logic [uvg_pkg::SEQ_W-1:0]        rnd_in;
  logic [uvg_pkg::CNT_W-1:0]        cnt_in, cnt_sat;
  logic [uvg_pkg::QPROD_W-1:0]      qprod;
  logic [uvg_pkg::TS_W-1:0]         ts_sum;
  logic [uvg_pkg::SEQ_W-1:0]        seq_sel;
  logic                             accept, reseed;

  assign sec     = in_data[33:0];
  assign nsec    = in_data[63:34];
  assign node_in = in_data[111:64];
  assign rnd_in  = in_data[125:112];
  assign cnt_in  = in_data[132:126];
  assign cnt_sat = (cnt_in > uvg_pkg::MAX_BATCH) ? uvg_pkg::MAX_BATCH : cnt_in;

  assign in_ready = !(v1 || v2 || v3);
  assign accept   = in_valid && in_ready;

  assign qprod = uvg_pkg::QPROD_W'(nsec) * uvg_pkg::QPROD_W'(uvg_pkg::RECIP_100);

  assign ts_sum = uvg_pkg::GREG_OFFSET
                + (uvg_pkg::TS_W'(p_hi) << uvg_pkg::SEC_HALF_W)
                + uvg_pkg::TS_W'(p_lo)
                + uvg_pkg::TS_W'(ticks);

  assign reseed  = (last_ts == '0) || (last_node != node3);
  assign seq_sel = reseed ? rnd3 :
                   (last_ts >= ts3) ? last_seq + uvg_pkg::SEQ_W'(1) : last_seq;

  assign push           = v3 && !q_full;
  assign push_cmd.ts    = ts3;
  assign push_cmd.seq   = seq_sel;
  assign push_cmd.node  = node3;
  assign push_cmd.count = cnt3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      last_ts   <= '0;
      last_node <= '0;
      last_seq  <= '0;
    end else begin
      v1 <= accept && (cnt_in != '0);
      v2 <= v1;
      if (v2) begin
        v3 <= 1'b1;
      end else if (push) begin
        v3 <= 1'b0;
      end
      if (push) begin
        last_node <= node3;
        last_seq  <= seq_sel;
        last_ts   <= ts3 + uvg_pkg::TS_W'(cnt3) - uvg_pkg::TS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_lo  <= uvg_pkg::PROD_W'(sec[uvg_pkg::SEC_HALF_W-1:0])
             * uvg_pkg::PROD_W'(uvg_pkg::TICKS_PER_SEC);
      p_hi  <= uvg_pkg::PROD_W'(sec[uvg_pkg::SEC_W-1:uvg_pkg::SEC_HALF_W])
             * uvg_pkg::PROD_W'(uvg_pkg::TICKS_PER_SEC);
      ticks <= qprod[uvg_pkg::QPROD_W-1:uvg_pkg::RECIP_SH];
      node1 <= node_in | (uvg_pkg::NODE_W'(in_random) << uvg_pkg::MCAST_BIT);
      rnd1  <= rnd_in;
      cnt1  <= cnt_sat;
    end
    if (v1) begin
      ts3   <= ts_sum;
      node2 <= node1;
      rnd2  <= rnd1;
      cnt2  <= cnt1;
    end
    if (v2) begin
      node3 <= node2;
      rnd3  <= rnd2;
      cnt3  <= cnt2;
    end
  end

endmodule

@@ hw/rtl/uvg_queue.sv @@
module uvg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  uvg_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output uvg_pkg::cmd_t pop_cmd,
  output logic          empty
);

  uvg_pkg::cmd_t mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    fill;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/uvg_back.sv @@
module uvg_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  uvg_pkg::cmd_t             q_cmd,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [uvg_pkg::OUT_W-1:0] out_data,
  output logic                      out_last
);

  logic                        active;
  logic [uvg_pkg::TS_W-1:0]    ts_cur;
  logic [uvg_pkg::CNT_W-1:0]   remain;
  logic [uvg_pkg::SEQ_W-1:0]   seq;
  logic [uvg_pkg::NODE_W-1:0]  node;
  logic                        emit, final_word;

  assign pop        = !active && !q_empty;
  assign emit       = active && (!out_valid || out_ready);
  assign final_word = (remain == uvg_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
      end else if (emit && final_word) begin
        active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ts_cur <= q_cmd.ts;
      remain <= q_cmd.count;
      seq    <= q_cmd.seq;
      node   <= q_cmd.node;
    end else if (emit) begin
      ts_cur <= ts_cur + uvg_pkg::TS_W'(1);
      remain <= remain - uvg_pkg::CNT_W'(1);
    end
    if (emit) begin
      out_data <= {node,
                   uvg_pkg::VARIANT_BITS, seq,
                   uvg_pkg::VERSION_NIB, ts_cur[59:48],
                   ts_cur[47:32],
                   ts_cur[31:0]};
      out_last <= final_word;
    end
  end

endmodule

@@ hw/rtl/uuid_v1_generator_top.sv @@
// Version-1 UUID generator.
// Input stream: one request word per accepted s_tvalid/s_tready beat. s_tdata
// carries seconds, nanoseconds, node address, random sequence and batch count;
// s_tuser flags a random node. A batch count of zero is dropped, above 64 it
// is clamped to 64.
// Output stream: one UUID word per m_tvalid/m_tready beat, m_tlast on the
// final UUID of each request.
// Path: three front stages for the tick conversion and sequence choice, the
// two-entry queue, the emitter's command registers and the output register.
// Throughput: one UUID per cycle while m_tready is high; the emitter pops the
// next request only after the final UUID of the current one. The front takes
// a new request only after pushing the previous one into the queue, and the
// two-entry queue lets it run ahead.
// Reset: clears the stored timestamp, node and sequence, empties the queue and
// drops any word in flight.
// Stall: a low m_tready holds the output word; the queue fills and s_tready
// then drops until space frees.
module uuid_v1_generator_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // seconds[33:0], nanoseconds[63:34], node_address[111:64],
  // random_sequence[125:112], batch_count[132:126], zero[135:133]
  input  logic [uvg_pkg::IN_W-1:0]  s_tdata,
  // node_is_random[0]
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // stamp_low[31:0], stamp_mid[47:32], time_hi_version[63:48],
  // clock_sequence[79:64], node_id[127:80]
  output logic [uvg_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tlast
);

  logic          push, pop, q_full, q_empty;
  uvg_pkg::cmd_t push_cmd, pop_cmd;

  uvg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .in_random (s_tuser),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  uvg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  uvg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

@@ verif/uuid_v1_generator_top_tb.sv @@
`timescale 1ns / 100ps

typedef struct packed {
  logic [33:0] sec;
  logic [29:0] nsec;
  logic [47:0] node;
  logic        is_random;
  logic [13:0] rseq;
  logic [6:0]  count;
} uuid_request_t;

typedef struct packed {
  logic [31:0] stamp_low;
  logic [15:0] stamp_mid;
  logic [15:0] time_hi_version;
  logic [15:0] clock_sequence;
  logic [47:0] node_id;
  logic        last;
} uuid_word_t;

class uuid_stream_check;
  localparam logic [63:0] EPOCH_TICKS = 64'h01B2_1DD2_1381_4000;
  localparam logic [63:0] TICKS_PER_S = 64'd10000000;
  localparam logic [63:0] NS_PER_TICK = 64'd100;
  localparam int          BATCH_MAX   = 64;

  logic [59:0] stamp_q;
  logic [47:0] node_q;
  logic [13:0] seq_q;
  uuid_word_t  pending_uuids[$];
  int          errors;
  int          word_idx;

  function new();
    stamp_q  = '0;
    node_q   = '0;
    seq_q    = '0;
    errors   = 0;
    word_idx = 0;
  endfunction

  function int pending();
    return pending_uuids.size();
  endfunction

  function void note_request(uuid_request_t r);
    logic [63:0] ticks;
    logic [59:0] stamp;
    logic [47:0] node;
    logic [13:0] seq;
    uuid_word_t  w;
    int          cnt;
    cnt = r.count;
    if (cnt == 0) return;
    if (cnt > BATCH_MAX) cnt = BATCH_MAX;
    node = r.node;
    if (r.is_random) node[40] = 1'b1;
    ticks = EPOCH_TICKS + {30'b0, r.sec} * TICKS_PER_S + {34'b0, r.nsec} / NS_PER_TICK;
    stamp = ticks[59:0];
    if (stamp_q == '0 || node_q != node) begin
      seq = r.rseq;
    end else if (stamp_q >= stamp) begin
      seq = seq_q + 14'd1;
    end else begin
      seq = seq_q;
    end
    node_q  = node;
    seq_q   = seq;
    stamp_q = stamp + 60'(cnt) - 60'd1;
    for (int n = 0; n < cnt; n++) begin
      w.stamp_low       = stamp[31:0];
      w.stamp_mid       = stamp[47:32];
      w.time_hi_version = {4'h1, stamp[59:48]};
      w.clock_sequence  = {2'b10, seq};
      w.node_id         = node;
      w.last            = (n == cnt - 1);
      pending_uuids.push_back(w);
      stamp = stamp + 60'd1;
    end
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t word %0d %s: got %h want %h", $time, word_idx, what, got, want);
    errors++;
  endtask

  task check_word(logic [127:0] data, logic last);
    uuid_word_t w;
    if (pending_uuids.size() == 0) begin
      report("unexpected word", {1'b0, data[127:80], 15'b0}, 64'b0);
    end else begin
      w = pending_uuids.pop_front();
      if (data[31:0] !== w.stamp_low) report("stamp_low", 64'(data[31:0]), 64'(w.stamp_low));
      if (data[47:32] !== w.stamp_mid) report("stamp_mid", 64'(data[47:32]), 64'(w.stamp_mid));
      if (data[63:48] !== w.time_hi_version)
        report("time_hi_version", 64'(data[63:48]), 64'(w.time_hi_version));
      if (data[79:64] !== w.clock_sequence)
        report("clock_sequence", 64'(data[79:64]), 64'(w.clock_sequence));
      if (data[127:80] !== w.node_id) report("node_id", 64'(data[127:80]), 64'(w.node_id));
      if (last !== w.last) report("last", 64'(last), 64'(w.last));
    end
    word_idx++;
  endtask
endclass

module uuid_v1_generator_top_tb;
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic         m_tlast;

  uuid_stream_check sb = new();

  int calm_items = 0;
  int stall_left = 0;
  int flow_left  = 0;

  uuid_v1_generator_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #40000000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
  end

  // receiver: short stalls mostly, a few long ones, and stretches of steady flow
  always @(negedge clk) begin
    int  r;
    logic nxt;
    nxt = 1'b1;
    if (flow_left > 0) begin
      flow_left--;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt = 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        flow_left = $urandom_range(50, 300);
      end else if (r < 5) begin
        stall_left = $urandom_range(8, 24);
        nxt = 1'b0;
      end else if (r < 30) begin
        stall_left = $urandom_range(0, 2);
        nxt = 1'b0;
      end
    end
    m_tready <= nxt;
  end

  function automatic int pick_gap();
    int r;
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm_items = $urandom_range(10, 30);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(uuid_request_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {3'b0, r.count, r.rseq, r.node, r.nsec, r.sec};
    s_tuser  <= r.is_random;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic issue(logic [33:0] sec, logic [29:0] nsec, logic [47:0] node,
                       logic is_random, logic [13:0] rseq, logic [6:0] count);
    uuid_request_t r;
    r.sec       = sec;
    r.nsec      = nsec;
    r.node      = node;
    r.is_random = is_random;
    r.rseq      = rseq;
    r.count     = count;
    send_request(r);
  endtask

  initial begin
    logic [33:0] s0;
    logic [33:0] cur_sec;
    logic [29:0] cur_nsec;
    logic [47:0] cur_node;
    logic        cur_rand;
    logic [6:0]  cnt;
    int          sent;
    int          r;
    int          d;

    s0 = 34'd1700000000;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first request after reset reseeds, then bump, keep, overlap, backward
    issue(s0, 30'd0, 48'h0123_4567_89AB, 1'b0, 14'h1234, 7'd1);
    issue(s0, 30'd0, 48'h0123_4567_89AB, 1'b0, 14'h0777, 7'd1);
    issue(s0, 30'd1000, 48'h0123_4567_89AB, 1'b0, 14'h0000, 7'd4);
    issue(s0, 30'd1200, 48'h0123_4567_89AB, 1'b0, 14'h0000, 7'd3);
    issue(s0, 30'd100, 48'h0123_4567_89AB, 1'b0, 14'h0000, 7'd2);
    // zero count is dropped
    issue(s0, 30'd5000, 48'h0123_4567_89AB, 1'b0, 14'h0000, 7'd0);
    // node change, then sequence wrap
    issue(s0, 30'd5000, 48'hFFFF_FFFF_FFFF, 1'b0, 14'h3FFF, 7'd1);
    issue(s0, 30'd5000, 48'hFFFF_FFFF_FFFF, 1'b0, 14'h0000, 7'd1);
    // random node forces the multicast bit
    issue(s0, 30'd5000, 48'h0000_0000_0000, 1'b1, 14'h0000, 7'd2);
    issue(s0, 30'd9000, 48'h0100_0000_0000, 1'b0, 14'h2AAA, 7'd1);
    issue(s0, 30'd9000, 48'h0000_0000_0000, 1'b0, 14'h1555, 7'd1);
    // field extremes and count saturation
    issue(34'd0, 30'd0, 48'h0000_0000_0000, 1'b0, 14'h3FFF, 7'd64);
    issue(34'h3_FFFF_FFFF, 30'd999999999, 48'hAAAA_AAAA_AAAA, 1'b1, 14'h2AAA, 7'd65);
    issue(34'h3_FFFF_FFFF, 30'h3FFF_FFFF, 48'hAAAA_AAAA_AAAA, 1'b1, 14'h0000, 7'd127);
    issue(34'h3_FFFF_FFFF, 30'h3FFF_FFFF, 48'hAAAA_AAAA_AAAA, 1'b1, 14'h0000, 7'd64);
    issue(s0, 30'd999999999, 48'h5555_5555_5555, 1'b0, 14'h0001, 7'd100);
    issue(s0 + 34'd1, 30'd0, 48'h5555_5555_5555, 1'b0, 14'h0000, 7'd1);
    issue(34'h3_FFFF_FFFF, 30'h3FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 14'h3FFF, 7'd0);

    cur_sec  = s0 + 34'd10;
    cur_nsec = 30'd0;
    cur_node = 48'({$urandom, $urandom});
    cur_rand = 1'b0;
    sent     = 0;
    while (sent < 440) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        cur_node = 48'({$urandom, $urandom});
        cur_rand = 1'($urandom_range(0, 1));
      end else if (r < 11) begin
        cur_rand = ~cur_rand;
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        d = $urandom_range(0, 3000);
        if (r < 20) d = $urandom_range(0, 64) * 100;
        cur_nsec = cur_nsec + 30'(d);
        if (cur_nsec >= 30'd1000000000) begin
          cur_nsec = cur_nsec - 30'd1000000000;
          cur_sec  = cur_sec + 34'd1;
        end
      end else if (r < 75) begin
        // hold time
      end else if (r < 87) begin
        d = $urandom_range(1, 5000);
        if (cur_nsec >= 30'(d)) cur_nsec = cur_nsec - 30'(d);
        else cur_sec = cur_sec - 34'd1;
      end else if (r < 95) begin
        cur_sec  = {2'($urandom_range(0, 3)), 32'($urandom)};
        cur_nsec = 30'($urandom_range(0, 999999999));
      end else begin
        cur_nsec = 30'($urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 70) cnt = 7'($urandom_range(1, 8));
      else if (r < 88) cnt = 7'($urandom_range(9, 63));
      else if (r < 94) cnt = 7'd64;
      else if (r < 97) cnt = 7'($urandom_range(65, 127));
      else cnt = 7'd0;
      issue(cur_sec, cur_nsec, cur_node, cur_rand, 14'($urandom), cnt);
      if (cnt != 7'd0) sent++;
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
